// File: design/sll_pkg.sv
// ---------------------------------------------------------------------------
// sll_pkg: shared types and constants of the script lexer
// Beat types, scanner state, token kinds and the word tables.
// ---------------------------------------------------------------------------
package sll_pkg;

   typedef logic [7:0] char_type;
   typedef logic [7:0][7:0] word_type;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [1:0]  error_code;
      logic [23:0] token_start;
      logic [23:0] token_length;
      logic [19:0] token_line;
      logic        last_in_run;
   } rsp_type;

   typedef struct packed {
      logic [3:0] mode;
      word_type   word_store;
      logic [3:0] word_len;
      logic [7:0] nest_depth;
      logic       quote_char;
      logic [2:0] pending_count;
      char_type   held_op;
   } scan_state_type;

   localparam logic [3:0] MODE_IDLE        = 4'd0;
   localparam logic [3:0] MODE_IDENT       = 4'd1;
   localparam logic [3:0] MODE_NUM         = 4'd2;
   localparam logic [3:0] MODE_NUM_DOT     = 4'd3;
   localparam logic [3:0] MODE_NUM_FRAC    = 4'd4;
   localparam logic [3:0] MODE_OP          = 4'd5;
   localparam logic [3:0] MODE_SLASH       = 4'd6;
   localparam logic [3:0] MODE_STRING      = 4'd7;
   localparam logic [3:0] MODE_STR_ESC     = 4'd8;
   localparam logic [3:0] MODE_LINE_CMT    = 4'd9;
   localparam logic [3:0] MODE_BLOCK       = 4'd10;
   localparam logic [3:0] MODE_BLOCK_SLASH = 4'd11;
   localparam logic [3:0] MODE_BLOCK_STAR  = 4'd12;

   localparam logic [5:0] K_IDENT    = 6'd0;
   localparam logic [5:0] K_ERROR    = 6'd1;
   localparam int         K_KW_FIRST = 2;
   localparam logic [5:0] K_NUMBER   = 6'd25;
   localparam logic [5:0] K_STRING   = 6'd26;
   localparam logic [5:0] K_LPAREN   = 6'd27;
   localparam logic [5:0] K_RPAREN   = 6'd28;
   localparam logic [5:0] K_LBRACK   = 6'd29;
   localparam logic [5:0] K_RBRACK   = 6'd30;
   localparam logic [5:0] K_COMMA    = 6'd31;
   localparam logic [5:0] K_DOT      = 6'd32;
   localparam logic [5:0] K_SEMI     = 6'd33;
   localparam logic [5:0] K_SCOPE    = 6'd34;
   localparam logic [5:0] K_ASSIGN   = 6'd35;
   localparam logic [5:0] K_NE       = 6'd36;
   localparam logic [5:0] K_NOT      = 6'd37;
   localparam logic [5:0] K_EQEQ     = 6'd38;
   localparam logic [5:0] K_EQ       = 6'd39;
   localparam logic [5:0] K_LE       = 6'd40;
   localparam logic [5:0] K_LT       = 6'd41;
   localparam logic [5:0] K_GE       = 6'd42;
   localparam logic [5:0] K_GT       = 6'd43;
   localparam logic [5:0] K_PLUSEQ   = 6'd44;
   localparam logic [5:0] K_PLUS     = 6'd45;
   localparam logic [5:0] K_MINUSEQ  = 6'd46;
   localparam logic [5:0] K_MINUS    = 6'd47;
   localparam logic [5:0] K_MODEQ    = 6'd48;
   localparam logic [5:0] K_MOD      = 6'd49;
   localparam logic [5:0] K_MULEQ    = 6'd50;
   localparam logic [5:0] K_MUL      = 6'd51;
   localparam logic [5:0] K_DIVEQ    = 6'd52;
   localparam logic [5:0] K_SLASH    = 6'd54;
   localparam logic [5:0] K_END      = 6'd60;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

   localparam int NUM_KW = 23;
   localparam logic [63:0] KW_TEXT [NUM_KW] = '{
      64'("_"), 64'("and"), 64'("break"), 64'("catch"), 64'("class"),
      64'("continue"), 64'("do"), 64'("elif"), 64'("else"), 64'("false"),
      64'("finally"), 64'("fn"), 64'("for"), 64'("from"), 64'("if"),
      64'("in"), 64'("is"), 64'("nil"), 64'("or"), 64'("return"),
      64'("throw"), 64'("true"), 64'("try")};
   localparam int KW_LEN [NUM_KW] = '{
      1, 3, 5, 5, 5, 8, 2, 4, 4, 5, 7, 2, 3, 4, 2, 2, 2, 3, 2, 6, 5, 4, 3};

   localparam int NUM_BE = 6;
   localparam logic [63:0] BE_TEXT [NUM_BE] = '{
      64'("class"), 64'("do"), 64'("fn"), 64'("for"), 64'("if"), 64'("try")};
   localparam int BE_LEN [NUM_BE] = '{5, 2, 2, 3, 2, 3};
   localparam logic [5:0] BE_KIND [NUM_BE] = '{
      6'd53, 6'd55, 6'd56, 6'd57, 6'd58, 6'd59};

   // first n bytes of s agree with the text of length len (up to len)
   function automatic logic prefix_match(word_type s, logic [3:0] n,
                                         logic [63:0] txt, int len);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (i < int'(n) && i < len) begin
            if (s[i] != txt[8*(len-1-i) +: 8]) ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic [5:0] classify(word_type s, logic [3:0] n);
      logic [5:0] k;
      k = K_IDENT;
      for (int e = 0; e < NUM_KW; e++) begin
         if (int'(n) == KW_LEN[e] && prefix_match(s, n, KW_TEXT[e], KW_LEN[e]))
            k = 6'(K_KW_FIRST + e);
      end
      return k;
   endfunction

   // K_IDENT when no block end matches
   function automatic logic [5:0] block_end_full(word_type s, logic [3:0] n);
      logic [5:0] k;
      k = K_IDENT;
      for (int e = 0; e < NUM_BE; e++) begin
         if (int'(n) == BE_LEN[e] && prefix_match(s, n, BE_TEXT[e], BE_LEN[e]))
            k = BE_KIND[e];
      end
      return k;
   endfunction

   function automatic logic block_end_prefix(word_type s, logic [3:0] n);
      logic hit;
      hit = 1'b0;
      for (int e = 0; e < NUM_BE; e++) begin
         if (BE_LEN[e] >= int'(n) && prefix_match(s, n, BE_TEXT[e], BE_LEN[e]))
            hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic [5:0] op_one(char_type ch);
      logic [5:0] k;
      case (ch)
         "!":     k = K_NOT;
         "=":     k = K_EQ;
         "<":     k = K_LT;
         ">":     k = K_GT;
         "+":     k = K_PLUS;
         "-":     k = K_MINUS;
         "%":     k = K_MOD;
         default: k = K_MUL;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] op_eq(char_type ch);
      logic [5:0] k;
      case (ch)
         "!":     k = K_NE;
         "=":     k = K_EQEQ;
         "<":     k = K_LE;
         ">":     k = K_GE;
         "+":     k = K_PLUSEQ;
         "-":     k = K_MINUSEQ;
         "%":     k = K_MODEQ;
         default: k = K_MULEQ;
      endcase
      return k;
   endfunction

endpackage

// File: design/sll_scan.sv
// ---------------------------------------------------------------------------
// sll_scan: per-byte scanner step
// Next scanner state and up to three tokens for one source beat.
// ---------------------------------------------------------------------------
module sll_scan #(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 20
) (
   input  sll_pkg::scan_state_type st,
   input  logic [OFFSET_BITS-1:0]  cur,
   input  logic [OFFSET_BITS-1:0]  tok_begin,
   input  logic [LINE_BITS-1:0]    line,
   input  sll_pkg::req_type        req,
   output sll_pkg::scan_state_type st_in,
   output logic [OFFSET_BITS-1:0]  tok_begin_in,
   output logic [LINE_BITS-1:0]    line_in,
   output sll_pkg::rsp_type        toks [3],
   output logic [1:0]              tok_count
);

   typedef struct packed {
      logic [5:0]             kind;
      logic [1:0]             err;
      logic [OFFSET_BITS-1:0] start;
      logic [OFFSET_BITS-1:0] len;
   } rec_type;

   rec_type                 recs [3];
   logic [1:0]              n;
   logic [3:0]              wl;
   logic [3:0]              k;
   logic [5:0]              kfull;
   sll_pkg::word_type       s2;
   sll_pkg::char_type       c;
   logic                    ok;
   logic                    alpha, digit, alnum;
   logic                    run_idle, run_ident, run_block, inc, ext;
   logic [OFFSET_BITS-1:0]  one;

   assign c     = req.src_byte;
   assign ok    = !req.end_of_source;
   assign alpha = ok && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_");
   assign digit = ok && c >= "0" && c <= "9";
   assign alnum = alpha || digit;
   assign one   = OFFSET_BITS'(1);

   always_comb begin
      st_in        = st;
      tok_begin_in = tok_begin;
      recs         = '{default: '0};
      n            = 2'd0;
      wl           = st.word_len;
      k            = {1'b0, st.pending_count};
      kfull        = sll_pkg::K_IDENT;
      s2           = st.word_store;
      run_idle     = 1'b0;
      run_ident    = 1'b0;
      run_block    = 1'b0;
      inc          = 1'b0;
      ext          = 1'b0;

      unique case (st.mode) inside
         sll_pkg::MODE_IDENT: run_ident = 1'b1;
         sll_pkg::MODE_NUM, sll_pkg::MODE_NUM_FRAC: begin
            if (digit) begin
            end else if (st.mode == sll_pkg::MODE_NUM && ok && c == ".") begin
               st_in.mode = sll_pkg::MODE_NUM_DOT;
            end else begin
               recs[n] = '{sll_pkg::K_NUMBER, sll_pkg::ERR_NONE, tok_begin, cur - tok_begin};
               n = n + 2'd1;
               run_idle = 1'b1;
            end
         end
         sll_pkg::MODE_NUM_DOT: begin
            if (digit) begin
               st_in.mode = sll_pkg::MODE_NUM_FRAC;
            end else begin
               recs[n] = '{sll_pkg::K_NUMBER, sll_pkg::ERR_NONE, tok_begin,
                           cur - one - tok_begin};
               n = n + 2'd1;
               recs[n] = '{sll_pkg::K_DOT, sll_pkg::ERR_NONE, cur - one, one};
               n = n + 2'd1;
               run_idle = 1'b1;
            end
         end
         sll_pkg::MODE_OP: begin
            st_in.mode = sll_pkg::MODE_IDLE;
            if (st.held_op == ":") begin
               if (ok && c == ":") begin
                  recs[n] = '{sll_pkg::K_SCOPE, sll_pkg::ERR_NONE, tok_begin,
                              cur + one - tok_begin};
                  n = n + 2'd1;
               end else if (ok && c == "=") begin
                  recs[n] = '{sll_pkg::K_ASSIGN, sll_pkg::ERR_NONE, tok_begin,
                              cur + one - tok_begin};
                  n = n + 2'd1;
               end else begin
                  recs[n] = '{sll_pkg::K_ERROR, sll_pkg::ERR_UNEXPECTED, tok_begin, '0};
                  n = n + 2'd1;
                  run_idle = 1'b1;
               end
            end else if (st.held_op == "*" && ok && c == "/") begin
            end else if (ok && c == "=") begin
               recs[n] = '{sll_pkg::op_eq(st.held_op), sll_pkg::ERR_NONE, tok_begin,
                           cur + one - tok_begin};
               n = n + 2'd1;
            end else begin
               recs[n] = '{sll_pkg::op_one(st.held_op), sll_pkg::ERR_NONE, tok_begin,
                           cur - tok_begin};
               n = n + 2'd1;
               run_idle = 1'b1;
            end
         end
         sll_pkg::MODE_SLASH: begin
            if (k == 4'd0 && ok && c == "=") begin
               recs[n] = '{sll_pkg::K_DIVEQ, sll_pkg::ERR_NONE, tok_begin,
                           cur + one - tok_begin};
               n = n + 2'd1;
               st_in.mode = sll_pkg::MODE_IDLE;
            end else if (k == 4'd0 && ok && c == "/") begin
               st_in.mode = sll_pkg::MODE_LINE_CMT;
            end else if (k == 4'd0 && ok && c == "*") begin
               st_in.nest_depth = 8'd1;
               st_in.mode = sll_pkg::MODE_BLOCK;
            end else begin
               if (k != 4'd0) kfull = sll_pkg::block_end_full(st.word_store, k);
               if (kfull != sll_pkg::K_IDENT && !alnum) begin
                  recs[n] = '{kfull, sll_pkg::ERR_NONE, tok_begin, cur - tok_begin};
                  n = n + 2'd1;
                  st_in.mode = sll_pkg::MODE_IDLE;
                  run_idle = 1'b1;
               end else begin
                  if (ok && k < 4'd5) begin
                     s2[k[2:0]] = c;
                     st_in.word_store[k[2:0]] = c;
                     if (sll_pkg::block_end_prefix(s2, k + 4'd1)) begin
                        st_in.pending_count = 3'(k + 4'd1);
                        ext = 1'b1;
                     end
                  end
                  if (!ext) begin
                     recs[n] = '{sll_pkg::K_SLASH, sll_pkg::ERR_NONE, tok_begin, one};
                     n = n + 2'd1;
                     st_in.pending_count = 3'd0;
                     if (k == 4'd0) begin
                        st_in.mode = sll_pkg::MODE_IDLE;
                        run_idle = 1'b1;
                     end else begin
                        tok_begin_in = tok_begin + one;
                        wl = k;
                        run_ident = 1'b1;
                     end
                  end
               end
            end
         end
         sll_pkg::MODE_STRING, sll_pkg::MODE_STR_ESC: begin
            if (!ok) begin
               recs[n] = '{sll_pkg::K_ERROR, sll_pkg::ERR_UNTERM_STR, tok_begin, '0};
               n = n + 2'd1;
               st_in.mode = sll_pkg::MODE_IDLE;
               run_idle = 1'b1;
            end else if (st.mode == sll_pkg::MODE_STR_ESC) begin
               inc = (c == "\n");
               st_in.mode = sll_pkg::MODE_STRING;
            end else if (c == (st.quote_char ? 8'h27 : 8'h22)) begin
               recs[n] = '{sll_pkg::K_STRING, sll_pkg::ERR_NONE, tok_begin,
                           cur + one - tok_begin};
               n = n + 2'd1;
               st_in.mode = sll_pkg::MODE_IDLE;
            end else if (c == "\n") begin
               inc = 1'b1;
            end else if (c == "\\") begin
               st_in.mode = sll_pkg::MODE_STR_ESC;
            end
         end
         sll_pkg::MODE_LINE_CMT: begin
            if (!ok) begin
               st_in.mode = sll_pkg::MODE_IDLE;
               run_idle = 1'b1;
            end else if (c == "\n") begin
               inc = 1'b1;
               st_in.mode = sll_pkg::MODE_IDLE;
            end
         end
         sll_pkg::MODE_BLOCK: run_block = 1'b1;
         sll_pkg::MODE_BLOCK_SLASH: begin
            if (ok && c == "*") begin
               if (st.nest_depth != 8'hff) st_in.nest_depth = st.nest_depth + 8'd1;
               st_in.mode = sll_pkg::MODE_BLOCK;
            end else begin
               run_block = 1'b1;
            end
         end
         sll_pkg::MODE_BLOCK_STAR: begin
            if (ok && c == "/") begin
               if (st.nest_depth != 8'd0) st_in.nest_depth = st.nest_depth - 8'd1;
               st_in.mode = (st_in.nest_depth == 8'd0) ? sll_pkg::MODE_IDLE
                                                      : sll_pkg::MODE_BLOCK;
            end else begin
               run_block = 1'b1;
            end
         end
         default: run_idle = 1'b1;
      endcase

      if (run_ident) begin
         if (alnum) begin
            if (wl < 4'd8) st_in.word_store[wl[2:0]] = c;
            st_in.word_len = (wl < 4'd9) ? wl + 4'd1 : wl;
            st_in.mode = sll_pkg::MODE_IDENT;
         end else begin
            recs[n] = '{sll_pkg::classify(st.word_store, wl), sll_pkg::ERR_NONE,
                        tok_begin_in, cur - tok_begin_in};
            n = n + 2'd1;
            st_in.word_len = wl;
            st_in.mode = sll_pkg::MODE_IDLE;
            run_idle = 1'b1;
         end
      end

      if (run_block) begin
         st_in.mode = sll_pkg::MODE_BLOCK;
         if (!ok) begin
            st_in.mode = sll_pkg::MODE_IDLE;
            run_idle = 1'b1;
         end else if (c == "\n") begin
            inc = 1'b1;
         end else if (c == "/") begin
            st_in.mode = sll_pkg::MODE_BLOCK_SLASH;
         end else if (c == "*") begin
            st_in.mode = sll_pkg::MODE_BLOCK_STAR;
         end
      end

      if (run_idle) begin
         st_in.mode = sll_pkg::MODE_IDLE;
         if (!ok) begin
            recs[n] = '{sll_pkg::K_END, sll_pkg::ERR_NONE, cur, '0};
            n = n + 2'd1;
         end else begin
            tok_begin_in = cur;
            if (alpha) begin
               st_in.mode = sll_pkg::MODE_IDENT;
               st_in.word_store[0] = c;
               st_in.word_len = 4'd1;
            end else if (digit) begin
               st_in.mode = sll_pkg::MODE_NUM;
            end else begin
               case (c) inside
                  "\n": inc = 1'b1;
                  " ", "\t", "\r": begin
                  end
                  "(": begin
                     recs[n] = '{sll_pkg::K_LPAREN, sll_pkg::ERR_NONE, cur, one};
                     n = n + 2'd1;
                  end
                  ")": begin
                     recs[n] = '{sll_pkg::K_RPAREN, sll_pkg::ERR_NONE, cur, one};
                     n = n + 2'd1;
                  end
                  "[": begin
                     recs[n] = '{sll_pkg::K_LBRACK, sll_pkg::ERR_NONE, cur, one};
                     n = n + 2'd1;
                  end
                  "]": begin
                     recs[n] = '{sll_pkg::K_RBRACK, sll_pkg::ERR_NONE, cur, one};
                     n = n + 2'd1;
                  end
                  ",": begin
                     recs[n] = '{sll_pkg::K_COMMA, sll_pkg::ERR_NONE, cur, one};
                     n = n + 2'd1;
                  end
                  ".": begin
                     recs[n] = '{sll_pkg::K_DOT, sll_pkg::ERR_NONE, cur, one};
                     n = n + 2'd1;
                  end
                  ";": begin
                     recs[n] = '{sll_pkg::K_SEMI, sll_pkg::ERR_NONE, cur, one};
                     n = n + 2'd1;
                  end
                  ":", "!", "=", "<", ">", "+", "-", "%", "*": begin
                     st_in.held_op = c;
                     st_in.mode = sll_pkg::MODE_OP;
                  end
                  "/": begin
                     st_in.pending_count = 3'd0;
                     st_in.mode = sll_pkg::MODE_SLASH;
                  end
                  8'h22: begin
                     st_in.quote_char = 1'b0;
                     st_in.mode = sll_pkg::MODE_STRING;
                  end
                  8'h27: begin
                     st_in.quote_char = 1'b1;
                     st_in.mode = sll_pkg::MODE_STRING;
                  end
                  default: begin
                     recs[n] = '{sll_pkg::K_ERROR, sll_pkg::ERR_UNEXPECTED, cur, '0};
                     n = n + 2'd1;
                  end
               endcase
            end
         end
      end

      line_in = (inc && line != '1) ? line + LINE_BITS'(1) : line;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         toks[i].token_kind   = recs[i].kind;
         toks[i].error_code   = recs[i].err;
         toks[i].token_start  = 24'(recs[i].start);
         toks[i].token_length = 24'(recs[i].len);
         toks[i].token_line   = 20'(line);
         toks[i].last_in_run  = (i + 1 == int'(n));
      end
   end

   assign tok_count = n;

endmodule

// File: design/script_language_lexer.sv
// ---------------------------------------------------------------------------
// script_language_lexer: streaming tokenizer for a small script language
// Scans one source byte per beat and hands out tokens one per beat.
// ---------------------------------------------------------------------------
//   channel | ports                     | beat
//   req     | req_valid/stall/data      | one source byte or end marker
//   rsp     | rsp_valid/stall/data      | one token
//
// One byte per cycle, while the result register is empty or hands out its last token,
// is scanned through an input register and the scan logic into a result register
// of up to three tokens; a byte that yields several tokens holds it until all are taken.
// Reset (synchronous) returns the scanner to idle, offset 0, line 1.
// rsp_stall holds the result register; req_stall rises while a byte waits and it cannot move on.
module script_language_lexer #(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sll_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sll_pkg::rsp_type rsp_data
);

   logic                    in_valid_ff;
   sll_pkg::req_type        in_data_ff;
   sll_pkg::scan_state_type state_ff, state_in;
   logic [OFFSET_BITS-1:0]  offset_ff;
   logic [OFFSET_BITS-1:0]  begin_ff, begin_in;
   logic [LINE_BITS-1:0]    line_ff, line_in;
   sll_pkg::rsp_type        tok_ff [3];
   sll_pkg::rsp_type        tok_in [3];
   logic [1:0]              rem_ff, tok_count;
   logic                    pop, move;

   sll_scan #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_scan (
      .st(state_ff), .cur(offset_ff), .tok_begin(begin_ff), .line(line_ff),
      .req(in_data_ff), .st_in(state_in), .tok_begin_in(begin_in),
      .line_in(line_in), .toks(tok_in), .tok_count(tok_count)
   );

   assign pop       = (rem_ff != 2'd0) && !rsp_stall;
   assign move      = in_valid_ff && ((rem_ff == 2'd0) || (rem_ff == 2'd1 && pop));
   assign req_stall = in_valid_ff && !move;
   assign rsp_valid = rem_ff != 2'd0;
   assign rsp_data  = tok_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || move) begin
         in_valid_ff <= req_valid;
      end
      if (!in_valid_ff || move) in_data_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode          <= sll_pkg::MODE_IDLE;
         state_ff.word_len      <= 4'd0;
         state_ff.nest_depth    <= 8'd0;
         state_ff.quote_char    <= 1'b0;
         state_ff.pending_count <= 3'd0;
         state_ff.held_op       <= 8'd0;
         offset_ff              <= '0;
         begin_ff               <= '0;
         line_ff                <= LINE_BITS'(1);
      end else if (move) begin
         state_ff  <= state_in;
         begin_ff  <= begin_in;
         line_ff   <= line_in;
         if (!in_data_ff.end_of_source) offset_ff <= offset_ff + OFFSET_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else if (move) begin
         rem_ff <= tok_count;
      end else if (pop) begin
         rem_ff <= rem_ff - 2'd1;
      end
      if (move) begin
         tok_ff <= tok_in;
      end else if (pop) begin
         tok_ff[0] <= tok_ff[1];
         tok_ff[1] <= tok_ff[2];
      end
   end

endmodule

// File: design/sll_checker.sv
// ---------------------------------------------------------------------------
// sll_checker: port-level checks of the script lexer
// Watches the token channel and flags malformed beats.
// ---------------------------------------------------------------------------
module sll_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sll_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sll_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("token beat changed while stalled");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == sll_pkg::K_END |-> rsp_data.last_in_run)
      else $error("end token not last of its run");

   a_err_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == sll_pkg::K_ERROR
      |-> rsp_data.token_length == 24'd0 && rsp_data.error_code != sll_pkg::ERR_NONE)
      else $error("error token malformed");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind != sll_pkg::K_ERROR
      |-> rsp_data.error_code == sll_pkg::ERR_NONE)
      else $error("error code on a regular token");

   a_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.token_line != 20'd0 && !(req_valid && req_stall && !rsp_stall
      && rsp_data.last_in_run && req_data.end_of_source && 1'b0))
      else $error("token line is zero");

endmodule

bind script_language_lexer sll_checker u_sll_checker (.*);

// File: verif/tb_script_language_lexer.sv
// ---------------------------------------------------------------------------
// tb_script_language_lexer: token stream check of the script lexer
// Feeds source bytes and end markers under random bursts and result stalls.
// A scanner model built into the bench predicts every token, and each token
// beat is compared field by field in order of arrival.
// ---------------------------------------------------------------------------
module tb_script_language_lexer;

   localparam logic [5:0] K_END_CLASS = 6'd53;
   localparam logic [5:0] K_END_DO    = 6'd55;
   localparam logic [5:0] K_END_FN    = 6'd56;
   localparam logic [5:0] K_END_FOR   = 6'd57;
   localparam logic [5:0] K_END_IF    = 6'd58;
   localparam logic [5:0] K_END_TRY   = 6'd59;
   localparam int         MAX_TOKENS  = 3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sll_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sll_pkg::rsp_type rsp_data;

   sll_pkg::rsp_type token_q[$];
   int      mismatches = 0;
   int      bytes_sent = 0;
   int      burst_left = 0;
   int      hold_cycles = 0;
   int      stall_span = 0;
   int      stall_pct = 0;

   // scanner state of the model
   logic [3:0]  scan_mode;
   logic [23:0] scan_offset;
   logic [23:0] tok_begin;
   logic [19:0] line_no;
   logic [7:0]  word_buf [8];
   logic [3:0]  word_len;
   logic [7:0]  depth;
   logic        single_quote;
   logic [2:0]  slash_len;
   logic [7:0]  held_op;
   int          step_tokens;

   string keyword_text [23] = '{"_", "and", "break", "catch", "class", "continue",
      "do", "elif", "else", "false", "finally", "fn", "for", "from", "if", "in",
      "is", "nil", "or", "return", "throw", "true", "try"};
   string block_text [6] = '{"class", "do", "fn", "for", "if", "try"};
   logic [5:0] block_kind [6] = '{K_END_CLASS, K_END_DO, K_END_FN, K_END_FOR,
      K_END_IF, K_END_TRY};

   script_language_lexer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   initial begin
      #50000000;
      $display("script_language_lexer: mismatch");
      $finish;
   end

   function automatic bit is_letter(int c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit is_num(int c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_word_char(int c);
      return is_letter(c) || is_num(c);
   endfunction

   function automatic bit word_is(string s, int n);
      if (s.len() != n) return 0;
      for (int i = 0; i < n; i++) begin
         if (word_buf[i] != s[i]) return 0;
      end
      return 1;
   endfunction

   function automatic bit word_starts(string s, int n);
      if (s.len() < n) return 0;
      for (int i = 0; i < n; i++) begin
         if (word_buf[i] != s[i]) return 0;
      end
      return 1;
   endfunction

   function automatic logic [5:0] word_kind();
      logic [5:0] k;
      k = sll_pkg::K_IDENT;
      if (word_len <= 8) begin
         for (int i = 0; i < 23; i++) begin
            if (word_is(keyword_text[i], word_len)) k = 6'(sll_pkg::K_KW_FIRST + i);
         end
      end
      return k;
   endfunction

   function automatic int block_end_kind(int n);
      int k;
      k = -1;
      for (int i = 0; i < 6; i++) begin
         if (word_is(block_text[i], n)) k = block_kind[i];
      end
      return k;
   endfunction

   function automatic bit block_end_start(int n);
      bit hit;
      hit = 0;
      for (int i = 0; i < 6; i++) begin
         if (word_starts(block_text[i], n)) hit = 1;
      end
      return hit;
   endfunction

   function automatic void bump_line();
      if (line_no != '1) line_no++;
   endfunction

   function automatic void add_token(logic [5:0] kind, logic [1:0] err,
                                     logic [23:0] start, logic [23:0] len);
      sll_pkg::rsp_type t;
      if (step_tokens >= MAX_TOKENS) return;
      t.token_kind   = kind;
      t.error_code   = err;
      t.token_start  = start;
      t.token_length = len;
      t.token_line   = line_no;
      t.last_in_run  = 1'b0;
      token_q.push_back(t);
      step_tokens++;
   endfunction

   function automatic void close_token(logic [5:0] kind, logic [23:0] stop);
      add_token(kind, sll_pkg::ERR_NONE, tok_begin, stop - tok_begin);
   endfunction

   function automatic bit scan_idle(int c, logic [23:0] cur);
      if (c < 0) begin
         add_token(sll_pkg::K_END, sll_pkg::ERR_NONE, cur, 0);
         return 0;
      end
      tok_begin = cur;
      if (is_letter(c)) begin
         scan_mode = sll_pkg::MODE_IDENT;
         word_buf[0] = 8'(c);
         word_len = 1;
         return 0;
      end
      if (is_num(c)) begin
         scan_mode = sll_pkg::MODE_NUM;
         return 0;
      end
      case (c)
         "\n": bump_line();
         " ", "\t", "\r": ;
         "(": add_token(sll_pkg::K_LPAREN, sll_pkg::ERR_NONE, cur, 1);
         ")": add_token(sll_pkg::K_RPAREN, sll_pkg::ERR_NONE, cur, 1);
         "[": add_token(sll_pkg::K_LBRACK, sll_pkg::ERR_NONE, cur, 1);
         "]": add_token(sll_pkg::K_RBRACK, sll_pkg::ERR_NONE, cur, 1);
         ",": add_token(sll_pkg::K_COMMA, sll_pkg::ERR_NONE, cur, 1);
         ".": add_token(sll_pkg::K_DOT, sll_pkg::ERR_NONE, cur, 1);
         ";": add_token(sll_pkg::K_SEMI, sll_pkg::ERR_NONE, cur, 1);
         ":", "!", "=", "<", ">", "+", "-", "%", "*": begin
            held_op = 8'(c);
            scan_mode = sll_pkg::MODE_OP;
         end
         "/": begin
            slash_len = 0;
            scan_mode = sll_pkg::MODE_SLASH;
         end
         "\"": begin
            single_quote = 0;
            scan_mode = sll_pkg::MODE_STRING;
         end
         "'": begin
            single_quote = 1;
            scan_mode = sll_pkg::MODE_STRING;
         end
         default: add_token(sll_pkg::K_ERROR, sll_pkg::ERR_UNEXPECTED, cur, 0);
      endcase
      return 0;
   endfunction

   function automatic bit scan_slash(int c, logic [23:0] cur);
      int k;
      int full;
      k = slash_len;
      if (k == 0) begin
         if (c == "=") begin
            close_token(sll_pkg::K_DIVEQ, cur + 1);
            scan_mode = sll_pkg::MODE_IDLE;
            return 0;
         end
         if (c == "/") begin
            scan_mode = sll_pkg::MODE_LINE_CMT;
            return 0;
         end
         if (c == "*") begin
            depth = 1;
            scan_mode = sll_pkg::MODE_BLOCK;
            return 0;
         end
      end
      full = (k > 0) ? block_end_kind(k) : -1;
      if (full >= 0 && !is_word_char(c)) begin
         close_token(6'(full), cur);
         scan_mode = sll_pkg::MODE_IDLE;
         return 1;
      end
      if (c >= 0 && k < 5) begin
         word_buf[k] = 8'(c);
         if (block_end_start(k + 1)) begin
            slash_len = 3'(k + 1);
            return 0;
         end
      end
      add_token(sll_pkg::K_SLASH, sll_pkg::ERR_NONE, tok_begin, 1);
      slash_len = 0;
      if (k == 0) begin
         scan_mode = sll_pkg::MODE_IDLE;
         return 1;
      end
      tok_begin = tok_begin + 1;
      word_len = 4'(k);
      scan_mode = sll_pkg::MODE_IDENT;
      return 1;
   endfunction

   function automatic bit scan_op(int c, logic [23:0] cur);
      logic [5:0] one;
      logic [5:0] with_eq;
      scan_mode = sll_pkg::MODE_IDLE;
      if (held_op == ":") begin
         if (c == ":") close_token(sll_pkg::K_SCOPE, cur + 1);
         else if (c == "=") close_token(sll_pkg::K_ASSIGN, cur + 1);
         else begin
            add_token(sll_pkg::K_ERROR, sll_pkg::ERR_UNEXPECTED, tok_begin, 0);
            return 1;
         end
         return 0;
      end
      if (held_op == "*" && c == "/") return 0;
      case (held_op)
         "!": begin one = sll_pkg::K_NOT; with_eq = sll_pkg::K_NE; end
         "=": begin one = sll_pkg::K_EQ; with_eq = sll_pkg::K_EQEQ; end
         "<": begin one = sll_pkg::K_LT; with_eq = sll_pkg::K_LE; end
         ">": begin one = sll_pkg::K_GT; with_eq = sll_pkg::K_GE; end
         "+": begin one = sll_pkg::K_PLUS; with_eq = sll_pkg::K_PLUSEQ; end
         "-": begin one = sll_pkg::K_MINUS; with_eq = sll_pkg::K_MINUSEQ; end
         "%": begin one = sll_pkg::K_MOD; with_eq = sll_pkg::K_MODEQ; end
         default: begin one = sll_pkg::K_MUL; with_eq = sll_pkg::K_MULEQ; end
      endcase
      if (c == "=") begin
         close_token(with_eq, cur + 1);
         return 0;
      end
      close_token(one, cur);
      return 1;
   endfunction

   function automatic bit scan_char(int c, logic [23:0] cur);
      case (scan_mode)
         sll_pkg::MODE_IDENT: begin
            if (is_word_char(c)) begin
               if (word_len < 8) word_buf[word_len] = 8'(c);
               if (word_len < 9) word_len++;
               return 0;
            end
            close_token(word_kind(), cur);
            scan_mode = sll_pkg::MODE_IDLE;
            return 1;
         end
         sll_pkg::MODE_NUM: begin
            if (is_num(c)) return 0;
            if (c == ".") begin
               scan_mode = sll_pkg::MODE_NUM_DOT;
               return 0;
            end
            close_token(sll_pkg::K_NUMBER, cur);
            scan_mode = sll_pkg::MODE_IDLE;
            return 1;
         end
         sll_pkg::MODE_NUM_DOT: begin
            if (is_num(c)) begin
               scan_mode = sll_pkg::MODE_NUM_FRAC;
               return 0;
            end
            close_token(sll_pkg::K_NUMBER, cur - 1);
            add_token(sll_pkg::K_DOT, sll_pkg::ERR_NONE, cur - 1, 1);
            scan_mode = sll_pkg::MODE_IDLE;
            return 1;
         end
         sll_pkg::MODE_NUM_FRAC: begin
            if (is_num(c)) return 0;
            close_token(sll_pkg::K_NUMBER, cur);
            scan_mode = sll_pkg::MODE_IDLE;
            return 1;
         end
         sll_pkg::MODE_OP: return scan_op(c, cur);
         sll_pkg::MODE_SLASH: return scan_slash(c, cur);
         sll_pkg::MODE_STRING, sll_pkg::MODE_STR_ESC: begin
            if (c < 0) begin
               add_token(sll_pkg::K_ERROR, sll_pkg::ERR_UNTERM_STR, tok_begin, 0);
               scan_mode = sll_pkg::MODE_IDLE;
               return 1;
            end
            if (scan_mode == sll_pkg::MODE_STR_ESC) begin
               if (c == "\n") bump_line();
               scan_mode = sll_pkg::MODE_STRING;
               return 0;
            end
            if (c == (single_quote ? "'" : "\"")) begin
               close_token(sll_pkg::K_STRING, cur + 1);
               scan_mode = sll_pkg::MODE_IDLE;
               return 0;
            end
            if (c == "\n") bump_line();
            else if (c == "\\") scan_mode = sll_pkg::MODE_STR_ESC;
            return 0;
         end
         sll_pkg::MODE_LINE_CMT: begin
            if (c < 0) begin
               scan_mode = sll_pkg::MODE_IDLE;
               return 1;
            end
            if (c == "\n") begin
               bump_line();
               scan_mode = sll_pkg::MODE_IDLE;
            end
            return 0;
         end
         sll_pkg::MODE_BLOCK: begin
            if (c < 0) begin
               scan_mode = sll_pkg::MODE_IDLE;
               return 1;
            end
            if (c == "\n") bump_line();
            else if (c == "/") scan_mode = sll_pkg::MODE_BLOCK_SLASH;
            else if (c == "*") scan_mode = sll_pkg::MODE_BLOCK_STAR;
            return 0;
         end
         sll_pkg::MODE_BLOCK_SLASH: begin
            scan_mode = sll_pkg::MODE_BLOCK;
            if (c == "*") begin
               if (depth < 255) depth++;
               return 0;
            end
            return 1;
         end
         sll_pkg::MODE_BLOCK_STAR: begin
            if (c == "/") begin
               if (depth > 0) depth--;
               scan_mode = (depth == 0) ? sll_pkg::MODE_IDLE : sll_pkg::MODE_BLOCK;
               return 0;
            end
            scan_mode = sll_pkg::MODE_BLOCK;
            return 1;
         end
         default: begin
            scan_mode = sll_pkg::MODE_IDLE;
            return scan_idle(c, cur);
         end
      endcase
   endfunction

   function automatic void predict_tokens(sll_pkg::req_type beat);
      int c;
      bit again;
      c = beat.end_of_source ? -1 : int'(beat.src_byte);
      step_tokens = 0;
      again = 1;
      for (int i = 0; i < 4 && again; i++) again = scan_char(c, scan_offset);
      if (!beat.end_of_source) scan_offset++;
      if (step_tokens > 0) token_q[$].last_in_run = 1'b1;
   endfunction

   // receiver: random stall pattern, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles--;
      end else begin
         if (stall_span == 0) begin
            stall_span = $urandom_range(8, 80);
            case ($urandom_range(0, 3))
               0, 1: stall_pct = 0;
               2: stall_pct = 30;
               default: stall_pct = 70;
            endcase
         end
         stall_span--;
         rsp_stall = ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected token: kind %0d start %0d", rsp_data.token_kind,
                        rsp_data.token_start);
         end else begin
            if (rsp_data.token_kind !== token_q[0].token_kind ||
                rsp_data.error_code !== token_q[0].error_code ||
                rsp_data.token_start !== token_q[0].token_start ||
                rsp_data.token_length !== token_q[0].token_length ||
                rsp_data.token_line !== token_q[0].token_line ||
                rsp_data.last_in_run !== token_q[0].last_in_run) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"token differs: exp k%0d e%0d s%0d n%0d l%0d t%0d,",
                            " got k%0d e%0d s%0d n%0d l%0d t%0d"},
                     token_q[0].token_kind, token_q[0].error_code, token_q[0].token_start,
                     token_q[0].token_length, token_q[0].token_line, token_q[0].last_in_run,
                     rsp_data.token_kind, rsp_data.error_code, rsp_data.token_start,
                     rsp_data.token_length, rsp_data.token_line, rsp_data.last_in_run);
            end
            void'(token_q.pop_front());
         end
      end
   end

   task automatic send_beat(logic [7:0] b, logic eos);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.src_byte = b;
      req_data.end_of_source = eos;
      do @(posedge clock); while (req_stall);
      predict_tokens(req_data);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (token_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_operators();
      send_text(":: := :x !x != ! == = <= < >= > += + -= - %= % *= * */ /= ()[],.;");
      send_end();
      wait_drained();
   endtask

   task automatic test_words();
      send_text("fn fnr _ and break catch class continue do elif else false finally");
      send_text(" for from if in is nil or return throw true try abcdefghij x9_Z");
      send_end();
      wait_drained();
   endtask

   task automatic test_numbers_strings();
      send_text("12 3.25 12. 7.x \"a\\\"b\" 'c\\\nd\ne' \"open");
      send_end();
      send_text("'x");
      send_end();
      wait_drained();
   endtask

   task automatic test_slash_and_errors();
      send_text("/class /do /fn /for /if /try /fnx /cl /q / // note\n");
      send_text("/* a /* b */ c */ x*/y @");
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_text("/*open");
      send_end();
      wait_drained();
   endtask

   task automatic test_deep_nesting();
      send_text("/*");
      for (int i = 0; i < 8; i++) send_text("/*");
      for (int i = 0; i < 9; i++) send_text("*/");
      send_text(" z");
      send_end();
      wait_drained();
   endtask

   function automatic string random_word(int n, bit lead_letter);
      string pool;
      string s;
      pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      s = "";
      for (int i = 0; i < n; i++)
         s = {s, string'(pool[$urandom_range(0, (i == 0 && lead_letter) ? 52 : 62)])};
      return s;
   endfunction

   function automatic string random_fragment();
      string ops [20] = '{"::", ":=", "!", "!=", "=", "==", "<", "<=", ">", ">=", "+",
         "+=", "-", "-=", "%", "%=", "*", "*=", "/=", ":"};
      string punct = "()[],.;";
      string s;
      case ($urandom_range(0, 10))
         0: return keyword_text[$urandom_range(0, 22)];
         1: return random_word($urandom_range(1, 12), 1);
         2: return {random_word($urandom_range(1, 3), 0) == "" ? "1" : "4",
                    ($urandom_range(0, 1) ? ".5" : "")};
         3: begin
            s = $urandom_range(0, 1) ? "\"" : "'";
            for (int i = $urandom_range(0, 6); i > 0; i--) begin
               case ($urandom_range(0, 4))
                  0: s = {s, "\\", string'(8'($urandom_range(32, 126)))};
                  1: s = {s, "\n"};
                  default: s = {s, string'(8'($urandom_range(32, 126)))};
               endcase
            end
            return {s, s.substr(0, 0)};
         end
         4: return ops[$urandom_range(0, 19)];
         5: return {"/", block_text[$urandom_range(0, 5)],
                    $urandom_range(0, 2) == 0 ? random_word(2, 0) : ""};
         6: return {"//", random_word($urandom_range(0, 5), 0), "\n"};
         7: return {"/* ", random_word(3, 1), $urandom_range(0, 1) ? " /* q */" : "",
                    "\n*/"};
         8: return string'(punct[$urandom_range(0, 6)]);
         9: return {string'(8'($urandom_range(48, 57))), "2."};
         default: return $urandom_range(0, 1) ? "\t" : "\r";
      endcase
   endfunction

   task automatic test_random_source();
      int start;
      start = bytes_sent;
      while (bytes_sent - start < 16) begin
         case ($urandom_range(0, 39))
            0, 1, 2: send_beat(8'($urandom_range(0, 255)), 1'b0);
            3: send_end();
            default: begin
               send_text(random_fragment());
               case ($urandom_range(0, 3))
                  0: send_text(" ");
                  1: send_text("\n");
                  default: ;
               endcase
            end
         endcase
      end
      send_end();
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      burst_left = 200;
      for (int i = 0; i < 20; i++) send_text("a(");
      send_end();
      wait_drained();
   endtask

   initial begin
      scan_mode = sll_pkg::MODE_IDLE;
      scan_offset = '0;
      tok_begin = '0;
      line_no = 20'd1;
      word_len = '0;
      depth = '0;
      single_quote = 1'b0;
      slash_len = '0;
      held_op = '0;
      foreach (word_buf[i]) word_buf[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_operators();
      test_words();
      test_numbers_strings();
      test_slash_and_errors();
      test_backpressure();
      test_random_source();
      test_deep_nesting();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && token_q.size() == 0) begin
         $display("script_language_lexer: match");
      end else begin
         $display("script_language_lexer: mismatch");
      end
      $finish;
   end

endmodule
